@@ src/cmet_pkg.sv @@
// shared types, widths and constants for the celtic mandelbrot escape-time engine
// no dependencies

package cmet_pkg;

    localparam int COORD_W = 32;
    localparam int STEP_W  = 31;
    localparam int PIX_W   = 10;
    localparam int ITER_W  = 12;
    localparam int FRAC_W  = 24;
    localparam int PROD_W  = 2 * COORD_W;
    localparam int MAPP_W  = PIX_W + STEP_W;
    localparam int WIDE_W  = MAPP_W + 2;
    localparam int DSH_W   = PROD_W - 2 - FRAC_W;
    localparam int TP_W    = PROD_W - (FRAC_W - 1);
    localparam int ADDR_W  = 5;
    localparam int REGI_W  = 3;
    localparam int DATA_W  = 32;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    localparam logic [PROD_W:0] ESC_LIMIT = (PROD_W + 1)'(4) << (2 * FRAC_W);

    localparam logic [REGI_W-1:0] REG_MIN_RE   = 3'd0;
    localparam logic [REGI_W-1:0] REG_MAX_IM   = 3'd1;
    localparam logic [REGI_W-1:0] REG_STEP_RE  = 3'd2;
    localparam logic [REGI_W-1:0] REG_STEP_IM  = 3'd3;
    localparam logic [REGI_W-1:0] REG_MAX_ITER = 3'd4;

    typedef struct packed {
        logic load;
        logic map;
        logic cinit;
        logic mul;
        logic chk;
        logic upd;
        logic out_load;
    } cmet_cmd_t;

    typedef struct packed {
        logic escape;
        logic out_free;
    } cmet_sts_t;

    localparam logic signed [WIDE_W-1:0] SAT_HI = WIDE_W'(32'sh7FFF_FFFF);
    localparam logic signed [WIDE_W-1:0] SAT_LO = WIDE_W'(-33'sh8000_0000);

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > SAT_HI) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < SAT_LO) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ src/cmet_ctrl.sv @@
// sequencing state machine for the escape-time engine
// depends on cmet_pkg

module cmet_ctrl import cmet_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  cmet_sts_t sts,
    output cmet_cmd_t cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MAP  = 3'd1;
    localparam logic [2:0] S_CMAP = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_CHK  = 3'd4;
    localparam logic [2:0] S_UPD  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_MAP;
                end
            end
            S_MAP: begin
                cmd.map    = 1'b1;
                state_next = S_CMAP;
            end
            S_CMAP: begin
                cmd.cinit  = 1'b1;
                state_next = S_MUL;
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_CHK;
            end
            S_CHK: begin
                cmd.chk    = 1'b1;
                state_next = sts.escape ? S_DONE : S_UPD;
            end
            S_UPD: begin
                cmd.upd    = 1'b1;
                state_next = S_MUL;
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cmd))
        else $error("more than one datapath command at once");

    a_upd_to_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.upd |=> cmd.mul)
        else $error("update not followed by multiply");

    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> !s_tready ##1 cmd.cinit)
        else $error("coordinate mapping sequence broken");

endmodule

@@ src/cmet_dp.sv @@
// datapath: coordinate mapping, iterate registers, multipliers, escape test, result register
// depends on cmet_pkg

module cmet_dp import cmet_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cmet_cmd_t                 cmd,
    output cmet_sts_t                 sts,
    input  logic [PIX_W-1:0]          pixel_x,
    input  logic [PIX_W-1:0]          pixel_y,
    input  logic signed [COORD_W-1:0] min_re,
    input  logic signed [COORD_W-1:0] max_im,
    input  logic [STEP_W-1:0]         step_re,
    input  logic [STEP_W-1:0]         step_im,
    input  logic [ITER_W-1:0]         max_iter,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [ITER_W-1:0]         iteration_count,
    output logic [PIX_W-1:0]          out_x,
    output logic [PIX_W-1:0]          out_y
);

    logic [PIX_W-1:0]          px_reg;
    logic [PIX_W-1:0]          py_reg;
    logic [MAPP_W-1:0]         pre_reg;
    logic [MAPP_W-1:0]         pim_reg;
    logic signed [COORD_W-1:0] c_re_reg;
    logic signed [COORD_W-1:0] c_im_reg;
    logic signed [COORD_W-1:0] re_reg;
    logic signed [COORD_W-1:0] im_reg;
    logic signed [PROD_W-1:0]  r2_reg;
    logic signed [PROD_W-1:0]  i2_reg;
    logic signed [PROD_W-1:0]  p_reg;
    logic [DSH_W-1:0]          dsh_reg;
    logic signed [TP_W-1:0]    tp_reg;
    logic [ITER_W-1:0]         count_reg;
    logic                      m_tvalid_reg;
    logic [ITER_W-1:0]         ocount_reg;
    logic [PIX_W-1:0]          ox_reg;
    logic [PIX_W-1:0]          oy_reg;

    logic signed [WIDE_W-1:0]  map_re;
    logic signed [WIDE_W-1:0]  map_im;
    logic [PROD_W:0]           mag_sum;
    logic [PROD_W-1:0]         diff;
    logic signed [WIDE_W-1:0]  re_sum;
    logic signed [WIDE_W-1:0]  im_sum;

    assign map_re  = WIDE_W'(min_re) + signed'({2'b00, pre_reg});
    assign map_im  = WIDE_W'(max_im) - signed'({2'b00, pim_reg});

    assign mag_sum = {1'b0, r2_reg} + {1'b0, i2_reg};
    assign diff    = (r2_reg >= i2_reg) ? PROD_W'(r2_reg - i2_reg) : PROD_W'(i2_reg - r2_reg);

    assign re_sum  = WIDE_W'(c_re_reg) + WIDE_W'(signed'({1'b0, dsh_reg}));
    assign im_sum  = WIDE_W'(c_im_reg) + WIDE_W'(tp_reg);

    assign sts.escape   = (mag_sum > ESC_LIMIT) || (count_reg >= max_iter);
    assign sts.out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            px_reg <= pixel_x;
            py_reg <= pixel_y;
        end
        if (cmd.map) begin
            pre_reg <= MAPP_W'(px_reg) * MAPP_W'(step_re);
            pim_reg <= MAPP_W'(py_reg) * MAPP_W'(step_im);
        end
        if (cmd.cinit) begin
            c_re_reg  <= sat32(map_re);
            c_im_reg  <= sat32(map_im);
            re_reg    <= sat32(map_re);
            im_reg    <= sat32(map_im);
            count_reg <= '0;
        end
        if (cmd.mul) begin
            r2_reg <= PROD_W'(re_reg) * PROD_W'(re_reg);
            i2_reg <= PROD_W'(im_reg) * PROD_W'(im_reg);
            p_reg  <= PROD_W'(re_reg) * PROD_W'(im_reg);
        end
        if (cmd.chk) begin
            dsh_reg <= diff[PROD_W-3:FRAC_W];
            tp_reg  <= p_reg[PROD_W-1:FRAC_W-1];
        end
        if (cmd.upd) begin
            re_reg    <= sat32(re_sum);
            im_reg    <= sat32(im_sum);
            count_reg <= count_reg + 1'b1;
        end
        if (cmd.out_load) begin
            ocount_reg <= count_reg;
            ox_reg     <= px_reg;
            oy_reg     <= py_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid        = m_tvalid_reg;
    assign iteration_count = ocount_reg;
    assign out_x           = ox_reg;
    assign out_y           = oy_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.chk |-> count_reg <= max_iter)
        else $error("iteration count beyond limit");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("pending result overwritten");

    a_update_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.upd |-> (re_sum == WIDE_W'(sat32(re_sum))) && (im_sum == WIDE_W'(sat32(im_sum))))
        else $error("iterate update left the coordinate range");

endmodule

@@ src/celtic_mandelbrot_escape_time.sv @@
// top level: register port, stream ports, controller and datapath
// depends on cmet_pkg, cmet_ctrl, cmet_dp
// operation: a taken input word is mapped to its point c, then each iteration steps through
// multiply, test and update, using one set of three 32x32 multipliers; the next input word
// is taken only once the result has been loaded into its output register, so one word at a time
// is in flight; a finished result waits in its own register
// reset: synchronous active-low aresetn clears the controller and output valid and loads
// the register defaults (-2.0, 2.0, 65600, 65600, 100)

module celtic_mandelbrot_escape_time import cmet_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,  // pixel_x, pixel_y, zero pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata   // iteration_count, out_x, out_y
);

    logic signed [COORD_W-1:0] min_re_reg;
    logic signed [COORD_W-1:0] max_im_reg;
    logic [STEP_W-1:0]         step_re_reg;
    logic [STEP_W-1:0]         step_im_reg;
    logic [ITER_W-1:0]         max_iter_reg;
    logic                      wr_en;
    logic [REGI_W-1:0]         reg_idx;
    cmet_cmd_t                 cmd;
    cmet_sts_t                 sts;
    logic [ITER_W-1:0]         iteration_count;
    logic [PIX_W-1:0]          out_x;
    logic [PIX_W-1:0]          out_y;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_re_reg   <= -32'sd33554432;
            max_im_reg   <= 32'sd33554432;
            step_re_reg  <= 31'd65600;
            step_im_reg  <= 31'd65600;
            max_iter_reg <= 12'd100;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_MIN_RE:   min_re_reg   <= signed'(pwdata);
                REG_MAX_IM:   max_im_reg   <= signed'(pwdata);
                REG_STEP_RE:  step_re_reg  <= pwdata[STEP_W-1:0];
                REG_STEP_IM:  step_im_reg  <= pwdata[STEP_W-1:0];
                REG_MAX_ITER: max_iter_reg <= pwdata[ITER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_MIN_RE:   prdata = unsigned'(min_re_reg);
            REG_MAX_IM:   prdata = unsigned'(max_im_reg);
            REG_STEP_RE:  prdata = DATA_W'(step_re_reg);
            REG_STEP_IM:  prdata = DATA_W'(step_im_reg);
            REG_MAX_ITER: prdata = DATA_W'(max_iter_reg);
            default:      prdata = '0;
        endcase
    end

    cmet_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cmet_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .pixel_x         (s_tdata[PIX_W-1:0]),
        .pixel_y         (s_tdata[2*PIX_W-1:PIX_W]),
        .min_re          (min_re_reg),
        .max_im          (max_im_reg),
        .step_re         (step_re_reg),
        .step_im         (step_im_reg),
        .max_iter        (max_iter_reg),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .iteration_count (iteration_count),
        .out_x           (out_x),
        .out_y           (out_y)
    );

    assign m_tdata = {out_y, out_x, iteration_count};

endmodule

@@ tb/sv/celtic_mandelbrot_escape_time_checker.sv @@
// checker for the celtic mandelbrot escape-time engine: follows register writes,
// predicts the iteration count of every pixel word taken and compares result words
// depends on cmet_pkg

module celtic_mandelbrot_escape_time_checker import cmet_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic                 pready,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    output int                   failures,
    output int                   pending
);

    typedef struct {
        logic [ITER_W-1:0] count;
        logic [PIX_W-1:0]  x;
        logic [PIX_W-1:0]  y;
    } pixel_result_t;

    logic signed [COORD_W-1:0] min_re;
    logic signed [COORD_W-1:0] max_im;
    logic [STEP_W-1:0]         step_re;
    logic [STEP_W-1:0]         step_im;
    logic [ITER_W-1:0]         max_iter;

    pixel_result_t expected_pixels[$];

    initial begin
        failures = 0;
        pending = 0;
    end

    function automatic longint clamp32(input longint v);
        longint r;
        r = v;
        if (v > 64'sh7FFF_FFFF) begin
            r = 64'sh7FFF_FFFF;
        end else if (v < -64'sh8000_0000) begin
            r = -64'sh8000_0000;
        end
        return r;
    endfunction

    function automatic logic [ITER_W-1:0] escape_count(input logic [PIX_W-1:0] px,
                                                        input logic [PIX_W-1:0] py);
        longint c_re, c_im, re, im, prod, shifted;
        longint unsigned mag_re, mag_im, r2, i2, diff;
        longint unsigned esc;
        int unsigned n;
        esc = 64'd4 << (2 * FRAC_W);
        c_re = clamp32(longint'(min_re) + longint'(px) * longint'(step_re));
        c_im = clamp32(longint'(max_im) - longint'(py) * longint'(step_im));
        re = c_re;
        im = c_im;
        n = 0;
        forever begin
            mag_re = (re < 0) ? -re : re;
            mag_im = (im < 0) ? -im : im;
            r2 = mag_re * mag_re;
            i2 = mag_im * mag_im;
            if (r2 + i2 > esc || n >= max_iter) begin
                break;
            end
            diff = (r2 >= i2) ? r2 - i2 : i2 - r2;
            prod = re * im;
            shifted = diff >> FRAC_W;
            re = clamp32(shifted + c_re);
            im = clamp32((prod >>> (FRAC_W - 1)) + c_im);
            n++;
        end
        return n[ITER_W-1:0];
    endfunction

    always @(posedge aclk) begin : watch
        pixel_result_t want;
        pixel_result_t got;
        if (!aresetn) begin
            min_re = -32'sd33554432;
            max_im = 32'sd33554432;
            step_re = 31'd65600;
            step_im = 31'd65600;
            max_iter = 12'd100;
            expected_pixels.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:2])
                    REG_MIN_RE:   min_re = pwdata;
                    REG_MAX_IM:   max_im = pwdata;
                    REG_STEP_RE:  step_re = pwdata[STEP_W-1:0];
                    REG_STEP_IM:  step_im = pwdata[STEP_W-1:0];
                    REG_MAX_ITER: max_iter = pwdata[ITER_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.count = m_tdata[ITER_W-1:0];
                got.x = m_tdata[ITER_W +: PIX_W];
                got.y = m_tdata[ITER_W+PIX_W +: PIX_W];
                if (expected_pixels.size() == 0) begin
                    $error("result word with nothing expected: count %0d x %0d y %0d",
                           got.count, got.x, got.y);
                    failures++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (got.count !== want.count) begin
                        $error("iteration_count: expected %0d, got %0d", want.count, got.count);
                        failures++;
                    end
                    if (got.x !== want.x) begin
                        $error("out_x: expected %0d, got %0d", want.x, got.x);
                        failures++;
                    end
                    if (got.y !== want.y) begin
                        $error("out_y: expected %0d, got %0d", want.y, got.y);
                        failures++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                want.x = s_tdata[0 +: PIX_W];
                want.y = s_tdata[PIX_W +: PIX_W];
                want.count = escape_count(want.x, want.y);
                expected_pixels.push_back(want);
            end
        end
        pending = expected_pixels.size();
    end

endmodule

@@ tb/sv/celtic_mandelbrot_escape_time_test.sv @@
// testbench top for the celtic mandelbrot escape-time engine: clock, reset, register
// writes, pixel words with random gaps and result back-pressure, watchdog and verdict
// depends on cmet_pkg, celtic_mandelbrot_escape_time, celtic_mandelbrot_escape_time_checker

module celtic_mandelbrot_escape_time_test import cmet_pkg::*;;

    localparam int STALL_LIMIT = 60000;
    localparam int PHASES      = 10;

    logic                  aclk;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [DATA_W-1:0]     pwdata;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;  // pixel_x, pixel_y, zero pad
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;  // iteration_count, out_x, out_y

    logic        s_took = 1'b0;
    logic        m_took = 1'b0;
    int          failures;
    int          pending;
    int unsigned tx_idle_max = 0;
    int unsigned rx_idle_max = 0;
    int          quiet_cycles = 0;

    celtic_mandelbrot_escape_time dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    celtic_mandelbrot_escape_time_checker chk (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .pready   (pready),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .failures (failures),
        .pending  (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // handshake flags, read at the falling edge
    always @(posedge aclk) begin
        s_took <= aresetn && (s_tvalid === 1'b1) && (s_tready === 1'b1);
        m_took <= aresetn && (m_tvalid === 1'b1) && (m_tready === 1'b1);
    end

    always @(negedge aclk) begin
        if (s_took || m_took || psel) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [REGI_W-1:0] idx, input logic [DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y);
        int unsigned gap;
        gap = $urandom_range(0, tx_idle_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= S_TDATA_W'({y, x});
        do @(negedge aclk); while (!s_took);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (12) @(negedge aclk);
    endtask

    task automatic set_window(input logic [DATA_W-1:0] iter_limit);
        write_reg(REG_MIN_RE, -$urandom_range(32'h0080_0000, 32'h0280_0000));
        write_reg(REG_MAX_IM, $urandom_range(32'h0080_0000, 32'h0200_0000));
        write_reg(REG_STEP_RE, $urandom_range(2000, 120000));
        write_reg(REG_STEP_IM, $urandom_range(2000, 120000));
        write_reg(REG_MAX_ITER, iter_limit);
    endtask

    initial begin : receiver
        int unsigned gap;
        m_tready = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            gap = $urandom_range(0, rx_idle_max);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(negedge aclk); while (!m_took);
        end
    end

    initial begin : stimulus
        int items;
        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset window: corners and points near the middle
        tx_idle_max = 15;
        rx_idle_max = 15;
        send_pixel(0, 0);
        send_pixel(1023, 1023);
        send_pixel(1023, 0);
        send_pixel(0, 1023);
        send_pixel(512, 512);
        send_pixel(300, 512);
        drain_results();

        // zero limit
        write_reg(REG_MAX_ITER, 0);
        send_pixel(512, 512);
        send_pixel(5, 1000);
        drain_results();

        // origin never escapes and runs to the top limit
        write_reg(REG_MIN_RE, 0);
        write_reg(REG_MAX_IM, 0);
        write_reg(REG_STEP_RE, 0);
        write_reg(REG_STEP_IM, 0);
        write_reg(REG_MAX_ITER, 4095);
        send_pixel(1023, 1023);
        drain_results();

        // exactly on the escape circle at 2.0, and at -2.0, whose orbit settles on the fixed point 2.0
        write_reg(REG_MIN_RE, 32'h0200_0000);
        send_pixel(7, 9);
        drain_results();
        write_reg(REG_MIN_RE, 32'hFE00_0000);
        send_pixel(0, 0);
        drain_results();

        // point mapped far outside the coordinate range saturates
        write_reg(REG_MIN_RE, 32'h7FFF_FFFF);
        write_reg(REG_MAX_IM, 32'h8000_0000);
        write_reg(REG_STEP_RE, 32'hFFFF_FFFF);
        write_reg(REG_STEP_IM, 32'h7FFF_FFFF);
        write_reg(REG_MAX_ITER, 32'hFFFF_FFFF);
        send_pixel(1023, 1023);
        send_pixel(0, 0);
        drain_results();

        // writes to unused addresses change nothing
        set_window(20);
        for (int i = REG_MAX_ITER + 1; i < 2 ** REGI_W; i++) begin
            write_reg(REGI_W'(i), $urandom);
        end
        send_pixel(100, 200);
        send_pixel(700, 300);
        drain_results();

        for (int phase = 0; phase < PHASES; phase++) begin
            tx_idle_max = (phase % 4 == 1) ? 0 : 15;
            rx_idle_max = (phase % 3 == 1) ? 0 : 15;
            case (phase % 5)
                0, 2: begin
                    set_window($urandom_range(1, 120));
                    items = 240;
                end
                1: begin
                    write_reg(REG_MIN_RE, $urandom);
                    write_reg(REG_MAX_IM, $urandom);
                    write_reg(REG_STEP_RE, $urandom);
                    write_reg(REG_STEP_IM, $urandom);
                    write_reg(REG_MAX_ITER, ($urandom & 32'hFFFF_F000) | $urandom_range(0, 63));
                    items = 120;
                end
                3: begin
                    set_window((phase < 5) ? 0 : 1);
                    items = 60;
                end
                default: begin
                    set_window(4095);
                    items = 8;
                end
            endcase
            for (int i = 0; i < items; i++) begin
                if ($urandom_range(0, 63) == 0) begin
                    drain_results();
                end
                send_pixel(PIX_W'($urandom_range(0, 1023)), PIX_W'($urandom_range(0, 1023)));
            end
            drain_results();
        end

        if (failures == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/cmet_pkg.sv
src/cmet_ctrl.sv
src/cmet_dp.sv
src/celtic_mandelbrot_escape_time.sv
tb/sv/celtic_mandelbrot_escape_time_checker.sv
tb/sv/celtic_mandelbrot_escape_time_test.sv
